/* hdl/hafp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafp_pkg
// Types, codes and constants for the handshake / ack frame parser.
// ----------------------------------------------------------------------------
package hafp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ChipIdW = 64;

  localparam logic [PosW-1:0] POS_ID_FIRST = 5'd4;
  localparam logic [PosW-1:0] POS_ID_LAST  = 5'd11;
  localparam logic [PosW-1:0] POS_PAYLOAD  = 5'd16;
  localparam logic [PosW-1:0] POS_SLEEP    = 5'd17;
  localparam logic [PosW-1:0] POS_RETRY    = 5'd18;
  localparam logic [PosW-1:0] POS_HS_END   = 5'd20;

  localparam logic [ByteW-1:0] PACKET_LIMIT_RESET = 8'd14;

  typedef enum logic [1:0] {
    PHASE_HANDSHAKE = 2'd0,
    PHASE_ACK       = 2'd1,
    PHASE_DONE      = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_HANDSHAKE = 2'd1,
    EV_ACK       = 2'd2
  } event_t;

  typedef enum logic {
    CFG_CHIP_ID      = 1'b0,
    CFG_PACKET_LIMIT = 1'b1
  } cfg_index_t;

  // "work" and "ackb"
  localparam logic [ByteW-1:0] HS_MARK  [4] = '{8'h77, 8'h6F, 8'h72, 8'h6B};
  localparam logic [ByteW-1:0] ACK_MARK [4] = '{8'h61, 8'h63, 8'h6B, 8'h62};

  function automatic logic [ByteW-1:0] mark_byte(input logic is_ack,
                                                 input logic [1:0] idx);
    mark_byte = is_ack ? ACK_MARK[idx] : HS_MARK[idx];
  endfunction

endpackage

/* hdl/handshake_ack_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handshake_ack_frame_parser
// Byte-wise parser for handshake and acknowledgement frames.
// The result of an accepted byte is registered and valid in the next cycle.
// Throughput: one byte per cycle; the phase/position registers double as
// the result register, so a new byte is taken whenever the result is free
// or is being taken in the same cycle.
// Reset: synchronous; phase handshake, position 0, captured values 0,
// chip_id 0, packet_limit 14, no result pending.
// ----------------------------------------------------------------------------
module handshake_ack_frame_parser
  import hafp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_res,
  output logic [1:0]         phase,
  output logic [ByteW-1:0]   assigned_index,
  output logic [ByteW-1:0]   sleep_time,
  output logic [ByteW-1:0]   retry_time,
  output logic [ByteW-1:0]   next_packet,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [ChipIdW-1:0] cfg_data
);

  logic [ChipIdW-1:0] chip_id;
  logic [ByteW-1:0]   packet_limit;

  phase_t           phase_reg, phase_next;
  logic [PosW-1:0]  byte_pos, byte_pos_next;
  event_t           event_reg, event_next;
  logic [ByteW-1:0] slot_reg, sleep_reg, retry_reg, packet_reg;
  logic [ByteW-1:0] hold_slot, hold_sleep, hold_retry;
  logic [ByteW-1:0] packet_next;

  logic             accept;
  logic             header_ok;
  logic [ByteW-1:0] expect_byte;
  logic [PosW-1:0]  id_off;
  logic [2:0]       id_sel;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_id      <= '0;
      packet_limit <= PACKET_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CHIP_ID:      chip_id      <= cfg_data;
        CFG_PACKET_LIMIT: packet_limit <= cfg_data[ByteW-1:0];
        default:          ;
      endcase
    end
  end

  // Header check for positions 0..15 (mark at 0..3, chip ID at 4..11, 12..15 unchecked)
  assign id_off = byte_pos - POS_ID_FIRST;
  assign id_sel = id_off[2:0];

  always_comb begin
    expect_byte = chip_id[{id_sel, 3'b000} +: ByteW];
    if (byte_pos < POS_ID_FIRST) begin
      expect_byte = mark_byte(phase_reg == PHASE_ACK, byte_pos[1:0]);
    end
    header_ok = (byte_pos > POS_ID_LAST) || (expect_byte == rx_byte);
  end

  assign packet_next = rx_byte + 8'd1;

  always_comb begin
    phase_next    = phase_reg;
    byte_pos_next = byte_pos;
    event_next    = EV_NONE;
    unique case (phase_reg)
      PHASE_HANDSHAKE: begin
        if (byte_pos > POS_HS_END) begin
          byte_pos_next = '0;
        end else if (byte_pos == POS_HS_END) begin
          event_next    = EV_HANDSHAKE;
          phase_next    = PHASE_ACK;
          byte_pos_next = '0;
        end else if (byte_pos >= POS_PAYLOAD) begin
          byte_pos_next = byte_pos + 5'd1;
        end else begin
          byte_pos_next = header_ok ? byte_pos + 5'd1 : '0;
        end
      end
      PHASE_ACK: begin
        if (byte_pos > POS_PAYLOAD) begin
          byte_pos_next = '0;
        end else if (byte_pos == POS_PAYLOAD) begin
          event_next    = EV_ACK;
          byte_pos_next = '0;
          if (packet_next >= packet_limit) begin
            phase_next = PHASE_DONE;
          end
        end else begin
          byte_pos_next = header_ok ? byte_pos + 5'd1 : '0;
        end
      end
      default: phase_next = PHASE_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= PHASE_HANDSHAKE;
      byte_pos   <= '0;
      event_reg  <= EV_NONE;
      out_valid  <= 1'b0;
      slot_reg   <= '0;
      sleep_reg  <= '0;
      retry_reg  <= '0;
      packet_reg <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        phase_reg <= phase_next;
        byte_pos  <= byte_pos_next;
        event_reg <= event_next;
        if (event_next == EV_HANDSHAKE) begin
          slot_reg  <= hold_slot;
          sleep_reg <= hold_sleep;
          retry_reg <= hold_retry;
        end
        if (event_next == EV_ACK) begin
          packet_reg <= packet_next;
        end
      end
    end
  end

  // Handshake payload holding registers
  always_ff @(posedge clk) begin
    if (accept && phase_reg == PHASE_HANDSHAKE) begin
      if (byte_pos == POS_PAYLOAD) hold_slot  <= rx_byte;
      if (byte_pos == POS_SLEEP)   hold_sleep <= rx_byte;
      if (byte_pos == POS_RETRY)   hold_retry <= rx_byte;
    end
  end

  assign event_res      = event_reg;
  assign phase          = phase_reg;
  assign assigned_index = slot_reg;
  assign sleep_time     = sleep_reg;
  assign retry_time     = retry_reg;
  assign next_packet    = packet_reg;

  a_hs_event_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_reg == EV_HANDSHAKE |-> phase_reg == PHASE_ACK)
    else $error("handshake event without ack phase");

  a_ack_pos_range: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PHASE_ACK |-> byte_pos <= POS_PAYLOAD)
    else $error("ack position out of range");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PHASE_DONE |=> phase_reg == PHASE_DONE)
    else $error("left done phase");

  a_hs_complete: assert property (@(posedge clk) disable iff (rst)
    accept && phase_reg == PHASE_HANDSHAKE && byte_pos == POS_HS_END
    |=> event_reg == EV_HANDSHAKE && slot_reg == $past(hold_slot))
    else $error("handshake completion missed");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && phase_reg == PHASE_DONE |=> event_reg == EV_NONE)
    else $error("event raised in done phase");

endmodule
